### rtl/core/ffca_pkg.sv
// Shared constants and types for the first-fit capability assigner.
// No dependencies; compiled first.
package ffca_pkg;

  localparam int REG_SERVERS  = 5;   // servers that have configuration registers
  localparam int REG_CLUSTERS = 6;   // cluster columns per service time register
  localparam int CAP_W        = 8;   // capability bits per server
  localparam int KIND_W       = 8;   // wanted_mask width
  localparam int TIME_W       = 7;   // service time per cluster
  localparam int TOTAL_W      = 9;   // saturating request total
  localparam int SRV_W        = 3;   // server_number width
  localparam int CL_W         = 3;   // cluster_number width
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 42;

  localparam int DEF_NUM_SERVERS        = 5;
  localparam int DEF_NUM_RESOURCE_KINDS = 8;
  localparam int DEF_NUM_CLUSTERS       = 6;

  // Register indexes; service time registers follow the capability register.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPABILITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_TIME_BASE = 3'd1;

  typedef logic [REG_SERVERS-1:0][CAP_W-1:0] cap_arr_t;
  typedef logic [REG_CLUSTERS-1:0][TIME_W-1:0] svc_row_t;

  // Register contents as seen by the assigner.
  typedef struct packed {
    cap_arr_t                    cap;
    logic [REG_SERVERS-1:0][REG_CLUSTERS*TIME_W-1:0] svc;
  } cfg_view_t;

endpackage

### rtl/core/ffca_if.sv
// Valid/ready channels of the first-fit capability assigner: request,
// result and configuration write. Depends on ffca_pkg.
interface ffca_req_if;
  import ffca_pkg::*;
  logic              valid;
  logic              ready;
  logic [CL_W-1:0]   cluster_number;
  logic [KIND_W-1:0] wanted_mask;
  modport source (output valid, cluster_number, wanted_mask, input ready);
  modport sink   (input valid, cluster_number, wanted_mask, output ready);
endinterface

interface ffca_rsp_if;
  import ffca_pkg::*;
  logic               valid;
  logic               ready;
  logic [SRV_W-1:0]   server_number;
  logic               last_of_run;
  logic               unservable;
  logic [TOTAL_W-1:0] cluster_total_time;
  logic [TOTAL_W-1:0] max_total_time;
  modport source (output valid, server_number, last_of_run, unservable,
                  cluster_total_time, max_total_time, input ready);
  modport sink   (input valid, server_number, last_of_run, unservable,
                  cluster_total_time, max_total_time, output ready);
endinterface

interface ffca_cfg_if;
  import ffca_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ffca_regs.sv
// Configuration registers: server capabilities and service times.
// Depends on ffca_pkg and ffca_cfg_if.
module ffca_regs #(
  parameter int NUM_SERVERS = ffca_pkg::DEF_NUM_SERVERS
) (
  input  logic                clk,
  input  logic                rst,
  ffca_cfg_if.sink            cfg,
  output ffca_pkg::cfg_view_t view
);
  import ffca_pkg::*;

  cap_arr_t cap;
  logic [REG_SERVERS-1:0][REG_CLUSTERS*TIME_W-1:0] svc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
      svc <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_CAPABILITY) begin
        cap <= cfg.data[REG_SERVERS*CAP_W-1:0];
      end
      for (int s = 0; s < REG_SERVERS; s++) begin
        if (cfg.index == CFG_IDX_W'(CFG_SVC_TIME_BASE + s)) begin
          svc[s] <= cfg.data;
        end
      end
    end
  end

  // servers past NUM_SERVERS never match
  always_comb begin
    for (int s = 0; s < REG_SERVERS; s++) begin
      view.cap[s] = (s < NUM_SERVERS) ? cap[s] : '0;
    end
    view.svc = svc;
  end

endmodule

### rtl/core/first_fit_capability_assigner_unit.sv
// First-fit capability assigner, top level.
// Depends on ffca_pkg, ffca_if (channels) and ffca_regs.
//
// A request (cluster_number, wanted_mask) is walked one resource kind per
// cycle unless a stall holds it, lowest kind first, by a one-hot token.
// For each still-wanted kind the lowest-numbered capable server is picked;
// all wanted kinds it covers are dropped and its service time for the
// cluster is added to a 9-bit saturating total. Each pick yields one result
// word (server counted from one). A kind with no capable server is dropped
// and flags the request as unservable. The last word of a request carries
// last_of_run, the unservable flag and the running maximum of request totals
// since reset; a request with no pick yields a single word with server 0 and
// total 0. One request at a time: the walk visits every kind, a closing
// state sends the last word, and the next request is taken back in idle.
// A pick that must push out the previous word, or the closing word, waits
// while the consumer still holds the result register. Up to five words
// per request. Config writes take effect on the next request and must land
// while idle.
module first_fit_capability_assigner_unit #(
  parameter int NUM_SERVERS        = ffca_pkg::DEF_NUM_SERVERS,
  parameter int NUM_RESOURCE_KINDS = ffca_pkg::DEF_NUM_RESOURCE_KINDS,
  parameter int NUM_CLUSTERS       = ffca_pkg::DEF_NUM_CLUSTERS
) (
  input  logic       clk,
  input  logic       rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp,
  ffca_cfg_if.sink   cfg
);
  import ffca_pkg::*;

  localparam int K            = NUM_RESOURCE_KINDS;
  localparam int EFF_CLUSTERS = (NUM_CLUSTERS < REG_CLUSTERS) ? NUM_CLUSTERS : REG_CLUSTERS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t state;

  cfg_view_t view;

  // request working set
  logic [K-1:0]                         want;
  logic [K-1:0]                         bit_sel;   // walking kind token
  logic [REG_SERVERS-1:0][TIME_W-1:0]   cl_time;   // cluster column latched at accept
  logic [TOTAL_W-1:0]                   total;
  logic                                 unserv;
  logic                                 pend_valid; // a picked word waits for last flag
  logic [SRV_W-1:0]                     pend_server;
  logic [TOTAL_W-1:0]                   run_max;

  // result register
  logic               out_valid;
  logic [SRV_W-1:0]   out_server;
  logic               out_last;
  logic               out_unserv;
  logic [TOTAL_W-1:0] out_total;
  logic [TOTAL_W-1:0] out_max;

  logic               hit;
  logic               found;
  logic [SRV_W-1:0]   sel;
  logic               out_free;
  logic               stall;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_add;
  logic [TOTAL_W-1:0] final_max;
  logic               cl_ok;

  ffca_regs #(
    .NUM_SERVERS(NUM_SERVERS)
  ) u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .view (view)
  );

  assign req.ready = (state == ST_IDLE);

  assign rsp.valid              = out_valid;
  assign rsp.server_number      = out_server;
  assign rsp.last_of_run        = out_last;
  assign rsp.unservable         = out_unserv;
  assign rsp.cluster_total_time = out_total;
  assign rsp.max_total_time     = out_max;

  assign out_free = !out_valid || rsp.ready;
  assign hit      = |(want & bit_sel);
  assign cl_ok    = req.cluster_number < CL_W'(EFF_CLUSTERS);

  // lowest capable server for the current kind
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int s = REG_SERVERS - 1; s >= 0; s--) begin
      if (|(view.cap[s][K-1:0] & bit_sel)) begin
        found = 1'b1;
        sel   = SRV_W'(s);
      end
    end
  end

  // a new pick must push the pending word out first
  assign stall = hit && found && pend_valid && !out_free;

  assign sum       = {1'b0, total} + (TOTAL_W + 1)'(cl_time[sel]);
  assign total_add = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign final_max = (total > run_max) ? total : run_max;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      run_max    <= '0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state      <= ST_SCAN;
            pend_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (bit_sel[K-1]) begin
              state <= ST_FINAL;
            end
            if (hit && found) begin
              pend_valid <= 1'b1;
              if (pend_valid) begin
                out_valid <= 1'b1;
              end
            end
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            run_max   <= final_max;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          want    <= req.wanted_mask[K-1:0];
          bit_sel <= K'(1);
          total   <= '0;
          unserv  <= 1'b0;
          for (int s = 0; s < REG_SERVERS; s++) begin
            cl_time[s] <= cl_ok ? view.svc[s][req.cluster_number*TIME_W +: TIME_W] : '0;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          bit_sel <= bit_sel << 1;
          if (hit) begin
            if (found) begin
              want        <= want & ~view.cap[sel][K-1:0];
              total       <= total_add;
              pend_server <= sel + SRV_W'(1);
              if (pend_valid) begin
                out_server <= pend_server;
                out_last   <= 1'b0;
                out_unserv <= 1'b0;
                out_total  <= total;
                out_max    <= '0;
              end
            end else begin
              want   <= want & ~bit_sel;
              unserv <= 1'b1;
            end
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_server <= pend_valid ? pend_server : '0;
          out_last   <= 1'b1;
          out_unserv <= unserv;
          out_total  <= total;
          out_max    <= final_max;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/ffca_check.sv
// Port-level checks for the first-fit capability assigner, bound to the
// top level. Depends on ffca_pkg and first_fit_capability_assigner_unit.
module ffca_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [ffca_pkg::SRV_W-1:0]   server_number,
  input logic                        last_of_run,
  input logic                        unservable,
  input logic [ffca_pkg::TOTAL_W-1:0] cluster_total_time,
  input logic [ffca_pkg::TOTAL_W-1:0] max_total_time
);
  import ffca_pkg::*;

  // stalled word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(server_number) &&
      $stable(cluster_total_time) && $stable(last_of_run))
    else $error("result word changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && last_of_run |-> max_total_time >= cluster_total_time)
    else $error("running max below request total");

  a_mid_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last_of_run |-> !unservable && max_total_time == '0 &&
      server_number != '0)
    else $error("bad intermediate word");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && server_number == '0 |-> last_of_run && cluster_total_time == '0)
    else $error("empty word not final or nonzero");

endmodule

bind first_fit_capability_assigner_unit ffca_check u_ffca_check (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .server_number      (rsp.server_number),
  .last_of_run        (rsp.last_of_run),
  .unservable         (rsp.unservable),
  .cluster_total_time (rsp.cluster_total_time),
  .max_total_time     (rsp.max_total_time)
);

### bench/tb_first_fit_capability_assigner_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for first_fit_capability_assigner_unit: predicts every result word.
// Depends on ffca_pkg, the channel interfaces of ffca_if and the block itself.
module tb_first_fit_capability_assigner_unit;
  import ffca_pkg::*;

  localparam int HALF_PERIOD   = 6;     // 12 ns clock
  localparam int RESET_CYCLES  = 7;
  localparam int IDLE_PCT      = 17;    // chance per cycle that a side idles
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES = 16;    // > one full walk, waited after the last word
  localparam int HOLD_CYCLES   = 250;   // long result hold-off for the backpressure test
  localparam int PHASE_ITEMS   = 64;
  localparam int NUM_PHASES    = 6;

  // Indexes past the register list: writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_SVC_TIME_BASE + REG_SERVERS);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(CFG_SPARE_LO + 1);
  localparam logic [CFG_DATA_W-1:0] ALL_ONES    = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_SAT   = '1;

  typedef struct packed {
    logic [SRV_W-1:0]   server_number;
    logic               last_of_run;
    logic               unservable;
    logic [TOTAL_W-1:0] cluster_total_time;
    logic [TOTAL_W-1:0] max_total_time;
  } result_word_t;

  logic clk = 1'b0;
  logic rst;

  ffca_req_if req_if ();
  ffca_rsp_if rsp_if ();
  ffca_cfg_if cfg_if ();

  first_fit_capability_assigner_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predictor state: register copies, running peak and the words still owed.
  cap_arr_t           cap_model  = '0;
  svc_row_t           svc_model [REG_SERVERS];
  logic [TOTAL_W-1:0] peak_total = '0;
  result_word_t       owed_words [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int rsp_hold_left  = 0;     // set by the backpressure test, counted down below
  bit req_quiet      = 1'b0;  // sender never idles
  bit rsp_quiet      = 1'b0;  // receiver never stalls

  initial begin
    foreach (svc_model[s]) svc_model[s] = '0;
  end

  // ---------------------------------------------------------------------------
  // First-fit walk: lowest wanted kind first, lowest capable server wins and
  // clears every wanted kind it covers. Kinds nobody serves are dropped and
  // flag the request. Cluster columns past the register row cost nothing.
  // ---------------------------------------------------------------------------
  function automatic void predict_assignment(logic [CL_W-1:0] cl, logic [KIND_W-1:0] mask);
    logic [KIND_W-1:0] want;
    int unsigned       total;
    logic              unserv;
    int                pick;
    result_word_t      words [$];
    result_word_t      w;
    want   = mask;
    total  = 0;
    unserv = 1'b0;
    for (int k = 0; k < KIND_W; k++) begin
      if (want[k]) begin
        pick = -1;
        for (int s = REG_SERVERS - 1; s >= 0; s--)
          if (cap_model[s][k]) pick = s;
        if (pick < 0) begin
          want[k] = 1'b0;
          unserv  = 1'b1;
        end else begin
          want &= ~cap_model[pick];
          if (cl < REG_CLUSTERS) total += svc_model[pick][cl];
          if (total > TOTAL_SAT) total = TOTAL_SAT;
          w = '0;
          w.server_number      = SRV_W'(pick + 1);
          w.cluster_total_time = TOTAL_W'(total);
          words = {words, w};
        end
      end
    end
    // nothing served: a single word with server 0 and total 0
    if (words.size() == 0) begin
      w = '0;
      words = {words, w};
    end
    if (total > peak_total) peak_total = TOTAL_W'(total);
    w = words.pop_back();
    w.last_of_run    = 1'b1;
    w.unservable     = unserv;
    w.max_total_time = peak_total;
    words = {words, w};
    owed_words = {owed_words, words};
  endfunction

  function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                      logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest owed one.
  // ---------------------------------------------------------------------------
  result_word_t want_w;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (owed_words.size() == 0) begin
        $error("unexpected result word: server_number %0d, cluster_total_time %0d",
               rsp_if.server_number, rsp_if.cluster_total_time);
        mismatch_count++;
      end else begin
        want_w = owed_words.pop_front();
        check_field("server_number", TOTAL_W'(want_w.server_number),
                    TOTAL_W'(rsp_if.server_number));
        check_field("last_of_run", TOTAL_W'(want_w.last_of_run),
                    TOTAL_W'(rsp_if.last_of_run));
        check_field("unservable", TOTAL_W'(want_w.unservable),
                    TOTAL_W'(rsp_if.unservable));
        check_field("cluster_total_time", want_w.cluster_total_time,
                    rsp_if.cluster_total_time);
        check_field("max_total_time", want_w.max_total_time, rsp_if.max_total_time);
      end
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, a counted hold-off on request, or always ready.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_left = rsp_hold_left - 1;
      end else begin
        rsp_if.ready <= rsp_quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel tasks. Everything is driven on the falling edge; acceptance is seen
  // on the rising edge. valid stays high after an accept until the next falling
  // edge decides: next word, idle gap, or drain.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [CL_W-1:0] cl, logic [KIND_W-1:0] mask);
    while (!req_quiet && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid          <= 1'b1;
    req_if.cluster_number <= cl;
    req_if.wanted_mask    <= mask;
    do @(posedge clk); while (!req_if.ready);
    predict_assignment(cl, mask);
  endtask

  task automatic send_random_request();
    logic [CL_W-1:0]   cl;
    logic [KIND_W-1:0] mask;
    // mostly real clusters; now and then the unused column codes
    if ($urandom_range(9) == 0) cl = CL_W'($urandom_range(7));
    else cl = CL_W'($urandom_range(REG_CLUSTERS - 1));
    case ($urandom_range(3))
      0:       mask = KIND_W'(1) << $urandom_range(KIND_W - 1);
      1:       mask = KIND_W'($urandom) & KIND_W'($urandom);
      default: mask = KIND_W'($urandom);
    endcase
    send_request(cl, mask);
  endtask

  // Stop offering, wait for every owed word, then let a full walk pass.
  task automatic drain_and_settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_CAPABILITY)
      cap_model = value[REG_SERVERS*CAP_W-1:0];
    else if (idx >= CFG_SVC_TIME_BASE && idx < CFG_SVC_TIME_BASE + REG_SERVERS)
      svc_model[idx - CFG_SVC_TIME_BASE] = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Full reprogram while idle; spare capability data bits carry random junk.
  task automatic load_setup(cap_arr_t caps, svc_row_t [REG_SERVERS-1:0] rows);
    logic [CFG_DATA_W-1:0] d;
    drain_and_settle();
    d = CFG_DATA_W'({$urandom, $urandom});
    d[REG_SERVERS*CAP_W-1:0] = caps;
    write_register(CFG_CAPABILITY, d);
    for (int s = 0; s < REG_SERVERS; s++)
      write_register(CFG_IDX_W'(CFG_SVC_TIME_BASE + s), rows[s]);
  endtask

  task automatic load_random_setup(int ceiling);
    cap_arr_t                   caps;
    svc_row_t [REG_SERVERS-1:0] rows;
    for (int s = 0; s < REG_SERVERS; s++) begin
      case ($urandom_range(5))
        0:       caps[s] = '0;
        1:       caps[s] = CAP_W'(1) << $urandom_range(CAP_W - 1);
        2:       caps[s] = CAP_W'($urandom) & CAP_W'($urandom);
        default: caps[s] = CAP_W'($urandom);
      endcase
      for (int c = 0; c < REG_CLUSTERS; c++)
        rows[s][c] = TIME_W'($urandom_range(ceiling));
    end
    load_setup(caps, rows);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at reset: nobody is capable of anything.
  task automatic test_unconfigured();
    send_request(3'd0, 8'h00);   // empty request
    send_request(3'd5, 8'hFF);   // every kind unservable
    send_request(3'd7, 8'h80);
  endtask

  task automatic test_extremes();
    svc_row_t [REG_SERVERS-1:0] rows;
    for (int s = 0; s < REG_SERVERS; s++)
      for (int c = 0; c < REG_CLUSTERS; c++)
        rows[s][c] = TIME_W'(10 * s + c + 1);
    // one low kind per server, upper nibble on the last: a full mask needs all five
    load_setup({8'hF0, 8'h08, 8'h04, 8'h02, 8'h01}, rows);
    send_request(3'd0, 8'hFF);
    send_request(3'd5, 8'hFF);
    send_request(3'd6, 8'hFF);   // cluster codes past the table cost nothing
    send_request(3'd7, 8'hFF);
    send_request(3'd1, 8'h00);
    send_request(3'd2, 8'h80);
    send_request(3'd3, 8'h55);
    send_request(3'd4, 8'h0A);
    // all servers capable of everything: server one takes the whole mask
    load_setup('1, rows);
    send_request(3'd3, 8'hFF);
    // only kind zero has a server; zero service times
    load_setup({32'h0, 8'h01}, '0);
    send_request(3'd0, 8'h03);   // partly served, rest unservable
    send_request(3'd1, 8'h02);   // nothing served at all
    send_request(3'd2, 8'hFE);
    // writes past the register list must leave the setup alone
    drain_and_settle();
    write_register(CFG_SPARE_LO, ALL_ONES);
    write_register(CFG_SPARE_HI, ALL_ONES);
    send_request(3'd5, 8'h01);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    load_random_setup(40);
    req_quiet     = 1'b1;
    rsp_hold_left = HOLD_CYCLES;
    repeat (8) send_random_request();
    req_quiet = 1'b0;
  endtask

  // Phases of random traffic, each on a fresh setup; time ceilings grow so the
  // running peak keeps moving. One phase runs with no idling on either side.
  task automatic test_random_phases();
    int ceilings [NUM_PHASES] = '{15, 31, 63, 90, 127, 127};
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_random_setup(ceilings[p]);
      req_quiet = (p == 3);
      rsp_quiet = (p == 3);
      repeat (PHASE_ITEMS) send_random_request();
    end
    req_quiet = 1'b0;
    rsp_quiet = 1'b0;
  endtask

  // Last, since the running peak sticks at the ceiling once saturated.
  task automatic test_saturation();
    load_setup({8'hF0, 8'h08, 8'h04, 8'h02, 8'h01}, ALL_ONES * 0 + {REG_SERVERS{ALL_ONES}});
    send_request(3'd2, 8'hFF);   // five picks of 127 clamp at the ceiling
    send_request(3'd7, 8'hFF);
    send_request(3'd0, 8'h0F);
  endtask

  initial begin
    rst                   <= 1'b1;
    req_if.valid          <= 1'b0;
    req_if.cluster_number <= '0;
    req_if.wanted_mask    <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unconfigured();
    test_extremes();
    test_backpressure();
    test_random_phases();
    test_saturation();
    drain_and_settle();

    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
